[sv/vfdpam_pkg.sv]
// ----------------------------------------------------------------------------
// vfdpam_pkg
// Shared types, constants and tables of the VFD pixel address map unit.
// ----------------------------------------------------------------------------
package vfdpam_pkg;

   // Geometry defaults and fixed frame size
   localparam int unsigned COLUMNS_DEF  = 112;
   localparam int unsigned ROWS_DEF     = 18;
   localparam int unsigned FRAME_BYTES  = 7168;
   localparam int unsigned FRAME_BITS   = FRAME_BYTES * 8;
   localparam int unsigned FRAME_OFFS   = 4;
   localparam int unsigned POS_W        = $clog2(FRAME_BITS + 1024);

   // Plane and column strides
   localparam int unsigned COL_STRIDE   = 1024;
   localparam int unsigned RED_OFS_T1   = 512;
   localparam int unsigned RED_OFS_T2   = 24;
   localparam int unsigned ROW_STEP_T1  = 16;
   localparam int unsigned ROW_STEP_T2  = 48;

   // Reciprocal of three, scaled by 2^9
   localparam int unsigned RECIP3       = 171;

   // Field widths
   localparam int unsigned COL_W        = 7;
   localparam int unsigned ROW_W        = 5;
   localparam int unsigned REQ_W        = 16;
   localparam int unsigned RSP_W        = 80;
   localparam int unsigned CSR_W        = 32;

   // Register indexes and panel layouts
   typedef enum logic {
      CSR_DISPLAY_TYPE = 1'b0,
      CSR_FRAME_BASE   = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      LAYOUT_NONE    = 2'd0,
      LAYOUT_INTERLV = 2'd1,
      LAYOUT_REMAP   = 2'd2,
      LAYOUT_RSVD    = 2'd3
   } layout_type;

   // Decoded column terms, handed from the first stage to the position stage
   typedef struct packed {
      logic             active;
      logic             remap;      // six-column layout, else interleave
      logic             x_nz;       // column is not zero
      logic             x_gt1;      // column above one
      logic             second;     // remap layout names a second cell
      logic [1:0]       x_mod4;
      logic [5:0]       x_half;     // (x-1)/2
      logic [5:0]       x_third;    // (x-1)/3
      logic [2:0]       letter;     // remapped letter slot
      logic [ROW_W-1:0] row;
      logic             color;
      logic [1:0]       panel;
      logic             pixel_on;
   } col_terms_type;

   // Letter remap of the six-column layout
   function automatic logic [2:0] letter_map(input logic [2:0] slot);
      logic [2:0] res;
      case (slot)
         3'd0:    res = 3'd0;
         3'd1:    res = 3'd2;
         3'd2:    res = 3'd4;
         3'd3:    res = 3'd5;
         3'd4:    res = 3'd3;
         3'd5:    res = 3'd1;
         default: res = 3'd0;
      endcase
      return res;
   endfunction

endpackage

[sv/vfdpam_pos_calc.sv]
// ----------------------------------------------------------------------------
// vfdpam_pos_calc
// Raw bit position of the primary and second cell, offset and wrapped.
// ----------------------------------------------------------------------------
module vfdpam_pos_calc
   import vfdpam_pkg::*;
(
   input  col_terms_type    terms,
   output logic [POS_W-1:0] pos1,
   output logic [POS_W-1:0] pos2
);

   logic [POS_W-1:0] base_t1;
   logic [POS_W-1:0] base_t2;
   logic [POS_W-1:0] raw1;
   logic [POS_W-1:0] raw2;
   logic [POS_W-1:0] off1;
   logic [POS_W-1:0] off2;

   // Build the layout terms
   always_comb begin
      base_t1 = POS_W'(terms.row) * POS_W'(ROW_STEP_T1)
              + (terms.color ? POS_W'(RED_OFS_T1) : '0)
              + POS_W'(terms.panel);
      base_t2 = POS_W'(terms.letter) * POS_W'(4)
              + (terms.color ? POS_W'(RED_OFS_T2) : '0)
              + POS_W'(terms.row) * POS_W'(ROW_STEP_T2)
              + POS_W'(terms.panel);
   end

   // Select the raw positions
   always_comb begin
      if (terms.remap) begin
         raw1 = base_t2 + (terms.x_gt1 ? POS_W'(terms.x_third) * POS_W'(COL_STRIDE) : '0);
         raw2 = terms.second
              ? base_t2 + (POS_W'(terms.x_third) + POS_W'(1)) * POS_W'(COL_STRIDE)
              : '0;
      end else begin
         raw1 = base_t1 + (terms.x_nz
              ? POS_W'(terms.x_mod4) * POS_W'(4) + POS_W'(terms.x_half) * POS_W'(COL_STRIDE)
              : '0);
         raw2 = '0;
      end
   end

   // Offset and wrap once at the frame size
   always_comb begin
      off1 = raw1 + POS_W'(FRAME_OFFS);
      off2 = raw2 + POS_W'(FRAME_OFFS);
      pos1 = (off1 >= POS_W'(FRAME_BITS)) ? off1 - POS_W'(FRAME_BITS) : off1;
      pos2 = (off2 >= POS_W'(FRAME_BITS)) ? off2 - POS_W'(FRAME_BITS) : off2;
   end

endmodule

[sv/vfd_pixel_address_map_unit.sv]
// ----------------------------------------------------------------------------
// vfd_pixel_address_map_unit
// Maps pixel requests to framebuffer byte addresses and bit numbers.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one pixel request per item (column, row, plane, panel, on).
//   rsp_* returns one item per request: active flag, primary byte address
//   and bit, set/clear, and an optional second cell for the remap layout.
//   csr_* writes display_type (index 0) and frame_base (index 1); write
//   only while no request is in flight.
// Pipeline: an accepted item passes through three register stages (column
//   decode, position sum with wrap, base add) in that order to rsp_*.
// Throughput: one item per cycle while rsp_tready is not holding the
//   output back; see Stall.
// Reset: synchronous; clears all stage valids and both registers.
// Stall: when rsp_tready is low the output item holds and the stages
//   behind it fill up; req_tready drops only when all three stages are
//   full, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module vfd_pixel_address_map_unit
   import vfdpam_pkg::*;
#(
   parameter int unsigned COLUMNS = COLUMNS_DEF,
   parameter int unsigned ROWS    = ROWS_DEF
)
(
   input  logic             clock,
   input  logic             reset,
   // column_x[6:0], row_y[11:7], color_sel[12], panel_index[14:13], pixel_on[15]
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             req_tvalid,
   output logic             req_tready,
   // active[0], byte_address[32:1], bit_index[35:33], set_bit[36],
   // second_valid[37], second_address[69:38], second_bit_index[72:70]
   output logic [RSP_W-1:0] rsp_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic             csr_wr_en,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   // Configuration registers
   layout_type       disp_type_ff, disp_type_in;
   logic [CSR_W-1:0] frame_base_ff, frame_base_in;

   // Stage valids and stage data
   logic             v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic             rdy1, rdy2, rdy3;
   col_terms_type    s1_ff, s1_in;
   logic             s2_active_ff, s2_on_ff, s2_second_ff;
   logic [POS_W-1:0] s2_pos1_ff, s2_pos2_ff;
   logic [POS_W-1:0] pos1, pos2;
   logic [RSP_W-1:0] rsp_ff, rsp_in;

   // Request fields
   logic [COL_W-1:0] col_x;
   logic [ROW_W-1:0] row_y;
   logic [COL_W-1:0] xm1;
   logic [15:0]      prod3, prod6;
   logic [5:0]       q3;
   logic [4:0]       q6;
   logic [COL_W-1:0] r6;
   logic [COL_W-1:0] r3;
   logic             type_ok;

   // Offsets within the frame
   logic [CSR_W-1:0] offs1, offs2;

   assign col_x = req_tdata[6:0];
   assign row_y = req_tdata[11:7];

   // Backward ready chain
   assign rdy3       = !v3_ff || rsp_tready;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;

   // Configuration writes
   always_comb begin
      disp_type_in  = disp_type_ff;
      frame_base_in = frame_base_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_DISPLAY_TYPE: disp_type_in  = layout_type'(csr_wdata[1:0]);
            CSR_FRAME_BASE:   frame_base_in = csr_wdata;
            default:          ;
         endcase
      end
   end

   // Stage 1: decode column terms by reciprocal of three
   always_comb begin
      xm1   = col_x - COL_W'(1);
      prod3 = 16'(xm1) * 16'(RECIP3);
      q3    = prod3[14:9];
      r3    = xm1 - COL_W'(q3) * COL_W'(3);
      prod6 = 16'(col_x) * 16'(RECIP3);
      q6    = prod6[14:10];
      r6    = col_x - COL_W'(q6) * COL_W'(6);
      type_ok = (disp_type_ff == LAYOUT_INTERLV) || (disp_type_ff == LAYOUT_REMAP);

      s1_in.active   = type_ok && (32'(col_x) < COLUMNS) && (32'(row_y) < ROWS);
      s1_in.remap    = (disp_type_ff == LAYOUT_REMAP);
      s1_in.x_nz     = (col_x != '0);
      s1_in.x_gt1    = (col_x > COL_W'(1));
      s1_in.second   = s1_in.remap && s1_in.x_gt1 && (r3 != '0);
      s1_in.x_mod4   = col_x[1:0];
      s1_in.x_half   = xm1[6:1];
      s1_in.x_third  = q3;
      s1_in.letter   = letter_map(r6[2:0]);
      s1_in.row      = row_y;
      s1_in.color    = req_tdata[12];
      s1_in.panel    = req_tdata[14:13];
      s1_in.pixel_on = req_tdata[15];
   end

   // Stage 2: raw positions
   vfdpam_pos_calc u_pos_calc (
      .terms (s1_ff),
      .pos1  (pos1),
      .pos2  (pos2)
   );

   // Stage 3: byte offset, big-endian byte swizzle, base add, nibble swap
   always_comb begin
      offs1 = CSR_W'({s2_pos1_ff[POS_W-1:5], ~s2_pos1_ff[4:3]});
      offs2 = CSR_W'({s2_pos2_ff[POS_W-1:5], ~s2_pos2_ff[4:3]});
      rsp_in = '0;
      if (s2_active_ff) begin
         rsp_in[0]     = 1'b1;
         rsp_in[32:1]  = frame_base_ff + offs1;
         rsp_in[35:33] = s2_pos1_ff[2:0] ^ 3'b100;
         rsp_in[36]    = s2_on_ff;
         rsp_in[37]    = s2_second_ff;
         rsp_in[69:38] = frame_base_ff + offs2;
         rsp_in[72:70] = s2_pos2_ff[2:0] ^ 3'b100;
      end
   end

   // Advance valids
   always_comb begin
      v1_in = rdy1 ? req_tvalid : v1_ff;
      v2_in = rdy2 ? v1_ff      : v2_ff;
      v3_in = rdy3 ? v2_ff      : v3_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         disp_type_ff  <= LAYOUT_NONE;
         frame_base_ff <= '0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
      end else begin
         disp_type_ff  <= disp_type_in;
         frame_base_ff <= frame_base_in;
         v1_ff         <= v1_in;
         v2_ff         <= v2_in;
         v3_ff         <= v3_in;
      end
   end

   // Payload registers, hold while stalled
   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_ff <= s1_in;
      end
      if (rdy2) begin
         s2_active_ff <= s1_ff.active;
         s2_on_ff     <= s1_ff.pixel_on;
         s2_second_ff <= s1_ff.second;
         s2_pos1_ff   <= pos1;
         s2_pos2_ff   <= pos2;
      end
      if (rdy3) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tdata  = rsp_ff;
   assign rsp_tvalid = v3_ff;

endmodule

[dv/tb_vfd_pixel_address_map_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vfd_pixel_address_map_unit
// Streams pixel requests through the address map unit under several panel
// layouts and framebuffer bases. A directed table runs first, then random
// requests. Every result is checked field by field against its table entry
// or an in-bench mapping function, with random idles on both stream sides.
// ----------------------------------------------------------------------------
module tb_vfd_pixel_address_map_unit
   import vfdpam_pkg::*;
();

   // Panel geometry and frame placement
   localparam int unsigned PANEL_COLS      = 112;
   localparam int unsigned PANEL_ROWS      = 18;
   localparam int unsigned FRAME_BIT_COUNT = 7168 * 8;
   localparam int unsigned BIT_SHIFT       = 4;
   localparam int unsigned DIR_ROWS        = 20;

   // Request fields, column in the lowest bits
   typedef struct packed {
      logic       pixel_on;
      logic [1:0] panel;
      logic       color;
      logic [4:0] row;
      logic [6:0] col;
   } pixel_req_type;

   // Result fields, active flag in the lowest bit
   typedef struct packed {
      logic [6:0]  pad;
      logic [2:0]  alt_bit;
      logic [31:0] alt_addr;
      logic        alt_valid;
      logic        set_bit;
      logic [2:0]  bit_num;
      logic [31:0] byte_addr;
      logic        active;
   } pixel_cell_type;

   // One directed request, with the settings it runs under
   typedef struct packed {
      layout_type     layout;
      logic [31:0]    base;
      pixel_req_type  req;
      logic           typed;
      pixel_cell_type want;
   } dir_row_type;

   localparam pixel_cell_type NO_WRITE    = '0;
   // Column 0, row 0, blue, panel 0 lands on bit 0 of byte 3
   localparam pixel_cell_type ORIGIN_CELL = '{7'd0, 3'd0, 32'd3, 1'b0, 1'b1, 3'd0, 32'd3,
                                              1'b1};

   // Letter slot order of the six-column layout
   localparam int unsigned SLOT_ORDER [6] = '{0, 2, 4, 5, 3, 1};

   // Requests: on, panel, plane, row, column
   localparam dir_row_type DIR_TABLE [DIR_ROWS] = '{
      // unknown layout after reset
      '{LAYOUT_NONE, 32'h0, '{1'b1, 2'd0, 1'b0, 5'd0, 7'd0}, 1'b1, NO_WRITE},
      '{LAYOUT_NONE, 32'h0, '{1'b1, 2'd3, 1'b1, 5'd17, 7'd111}, 1'b1, NO_WRITE},
      // four-column interleave
      '{LAYOUT_INTERLV, 32'h0, '{1'b1, 2'd0, 1'b0, 5'd0, 7'd0}, 1'b1, ORIGIN_CELL},
      '{LAYOUT_INTERLV, 32'h0, '{1'b0, 2'd0, 1'b0, 5'd0, 7'd0}, 1'b0, NO_WRITE},
      '{LAYOUT_INTERLV, 32'h0, '{1'b1, 2'd0, 1'b0, 5'd0, 7'd1}, 1'b0, NO_WRITE},
      '{LAYOUT_INTERLV, 32'h0, '{1'b1, 2'd3, 1'b1, 5'd17, 7'd111}, 1'b0, NO_WRITE},
      '{LAYOUT_INTERLV, 32'h0, '{1'b1, 2'd0, 1'b0, 5'd0, 7'd112}, 1'b1, NO_WRITE},
      '{LAYOUT_INTERLV, 32'h0, '{1'b1, 2'd0, 1'b0, 5'd18, 7'd0}, 1'b1, NO_WRITE},
      '{LAYOUT_INTERLV, 32'h0, '{1'b1, 2'd3, 1'b1, 5'd31, 7'd127}, 1'b1, NO_WRITE},
      '{LAYOUT_INTERLV, 32'h0, '{1'b0, 2'd2, 1'b1, 5'd5, 7'd2}, 1'b0, NO_WRITE},
      // six-column remap, with and without a second cell
      '{LAYOUT_REMAP, 32'h0, '{1'b1, 2'd0, 1'b0, 5'd0, 7'd0}, 1'b0, NO_WRITE},
      '{LAYOUT_REMAP, 32'h0, '{1'b1, 2'd0, 1'b0, 5'd0, 7'd1}, 1'b0, NO_WRITE},
      '{LAYOUT_REMAP, 32'h0, '{1'b1, 2'd0, 1'b0, 5'd0, 7'd2}, 1'b0, NO_WRITE},
      '{LAYOUT_REMAP, 32'h0, '{1'b1, 2'd1, 1'b1, 5'd3, 7'd4}, 1'b0, NO_WRITE},
      '{LAYOUT_REMAP, 32'h0, '{1'b1, 2'd3, 1'b1, 5'd17, 7'd110}, 1'b0, NO_WRITE},
      '{LAYOUT_REMAP, 32'h0, '{1'b0, 2'd3, 1'b1, 5'd17, 7'd111}, 1'b0, NO_WRITE},
      '{LAYOUT_REMAP, 32'h0, '{1'b1, 2'd0, 1'b0, 5'd17, 7'd112}, 1'b1, NO_WRITE},
      // reserved layout, then base wrap past the top of the address space
      '{LAYOUT_RSVD, 32'hFFFF_FFFF, '{1'b1, 2'd1, 1'b1, 5'd5, 7'd5}, 1'b1, NO_WRITE},
      '{LAYOUT_INTERLV, 32'hFFFF_FFFF, '{1'b1, 2'd0, 1'b0, 5'd0, 7'd0}, 1'b0, NO_WRITE},
      '{LAYOUT_INTERLV, 32'hFFFF_FFFF, '{1'b1, 2'd3, 1'b1, 5'd17, 7'd111}, 1'b0, NO_WRITE}
   };

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic             csr_wr_en = 1'b0;
   csr_index_type    csr_index = CSR_DISPLAY_TYPE;
   logic [CSR_W-1:0] csr_wdata = '0;

   // Register copies seen by the mapping function
   layout_type  cur_layout = LAYOUT_NONE;
   logic [31:0] cur_base = '0;

   pixel_cell_type cell_queue [$];
   int             mismatch_count = 0;
   logic           steady = 1'b0;

   vfd_pixel_address_map_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Turn a raw bit position into a swizzled byte address and bit number
   function automatic void place_bit(input int unsigned raw, output logic [31:0] addr,
                                     output logic [2:0] bnum);
      int unsigned pos;
      pos = raw + BIT_SHIFT;
      if (pos >= FRAME_BIT_COUNT)
         pos -= FRAME_BIT_COUNT;
      addr = cur_base + (pos / 32) * 4 + (3 - (pos % 32) / 8);
      bnum = 3'((pos % 8) ^ 4);
   endfunction

   // Framebuffer cell(s) touched by one pixel request
   function automatic pixel_cell_type map_pixel(input pixel_req_type r);
      pixel_cell_type c;
      int unsigned x, y, lane, raw1, raw2;
      logic [31:0] a1, a2;
      logic [2:0]  b1, b2;
      logic        more;
      c    = '0;
      raw2 = 0;
      more = 1'b0;
      x    = 32'(r.col);
      y    = 32'(r.row);
      if ((cur_layout != LAYOUT_INTERLV && cur_layout != LAYOUT_REMAP) ||
          x >= PANEL_COLS || y >= PANEL_ROWS)
         return c;
      if (cur_layout == LAYOUT_INTERLV) begin
         raw1 = y * 16 + 32'(r.color) * 512 + 32'(r.panel);
         if (x != 0)
            raw1 += (x % 4) * 4 + ((x - 1) / 2) * 1024;
      end else begin
         lane = SLOT_ORDER[3'(x % 6)] * 4 + 32'(r.color) * 24 + y * 48 + 32'(r.panel);
         raw1 = lane;
         if (x > 1) begin
            raw1 += ((x - 1) / 3) * 1024;
            if ((x - 1) % 3 != 0) begin
               more = 1'b1;
               raw2 = lane + ((x - 1) / 3 + 1) * 1024;
            end
         end
      end
      place_bit(raw1, a1, b1);
      place_bit(raw2, a2, b2);
      c.active    = 1'b1;
      c.byte_addr = a1;
      c.bit_num   = b1;
      c.set_bit   = r.pixel_on;
      c.alt_valid = more;
      c.alt_addr  = a2;
      c.alt_bit   = b2;
      return c;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s expected %0h got %0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // Stall the result side about one cycle in ten, never while steady
   always @(posedge clock) begin
      rsp_tready <= !reset && (steady || $urandom_range(0, 99) >= 10);
   end

   // Compare every accepted result with the oldest pending cell
   always @(posedge clock) begin : check_results
      pixel_cell_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (cell_queue.size() == 0) begin
            $display("%0t ns: result with nothing pending, got %h", $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want = cell_queue.pop_front();
            check_field("active", 32'(want.active), 32'(got.active));
            check_field("byte_address", want.byte_addr, got.byte_addr);
            check_field("bit_index", 32'(want.bit_num), 32'(got.bit_num));
            check_field("set_bit", 32'(want.set_bit), 32'(got.set_bit));
            check_field("second_valid", 32'(want.alt_valid), 32'(got.alt_valid));
            check_field("second_address", want.alt_addr, got.alt_addr);
            check_field("second_bit_index", 32'(want.alt_bit), 32'(got.alt_bit));
            check_field("padding", 32'(want.pad), 32'(got.pad));
         end
      end
   end

   // Offer one item, idling first at random, and hold until it is taken
   task automatic send_item(input pixel_req_type r, input pixel_cell_type want);
      while (!steady && $urandom_range(0, 99) < 10) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= r;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      cell_queue.push_back(want);
   endtask

   // Stop offering and wait for every pending result
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (cell_queue.size() != 0)
         @(posedge clock);
   endtask

   // Write both registers once the block is empty
   task automatic load_settings(input layout_type lay, input logic [31:0] base);
      drain_results();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_DISPLAY_TYPE;
      csr_wdata <= 32'(lay);
      @(posedge clock);
      csr_index <= CSR_FRAME_BASE;
      csr_wdata <= base;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      cur_layout = lay;
      cur_base   = base;
   endtask

   initial begin : stimulus
      layout_type    phase_layout [10];
      logic [31:0]   phase_base [10];
      pixel_req_type r;
      dir_row_type   drow;
      int            i, k, n;
      phase_layout = '{LAYOUT_INTERLV, LAYOUT_REMAP, LAYOUT_INTERLV, LAYOUT_NONE,
                       LAYOUT_REMAP, LAYOUT_RSVD, LAYOUT_REMAP, LAYOUT_INTERLV,
                       LAYOUT_REMAP, LAYOUT_INTERLV};
      phase_base   = '{32'h0, 32'hFFFF_FFFF, 32'hFFFF_E400, 32'h8000_0000, 32'h0,
                       32'hFFFF_FFFF, 32'hFFFF_F000, 32'h0, 32'h0, 32'h0};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed table, reconfiguring only where a row asks for new settings
      for (i = 0; i < DIR_ROWS; i++) begin
         drow = DIR_TABLE[5'(i)];
         if (drow.layout != cur_layout || drow.base != cur_base)
            load_settings(drow.layout, drow.base);
         send_item(drow.req, drow.typed ? drow.want : map_pixel(drow.req));
      end

      // Random phases, mostly in-range pixels, some anywhere in the field range
      for (i = 0; i < 10; i++) begin
         if (i >= 7)
            phase_base[4'(i)] = $urandom();
         load_settings(phase_layout[4'(i)], phase_base[4'(i)]);
         steady = (i == 4);
         n = (phase_layout[4'(i)] == LAYOUT_INTERLV || phase_layout[4'(i)] == LAYOUT_REMAP)
             ? 110 : 30;
         for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 15) begin
               r.col = 7'($urandom_range(0, 127));
               r.row = 5'($urandom_range(0, 31));
            end else begin
               r.col = 7'($urandom_range(0, PANEL_COLS - 1));
               r.row = 5'($urandom_range(0, PANEL_ROWS - 1));
            end
            r.color    = 1'($urandom_range(0, 1));
            r.panel    = 2'($urandom_range(0, 3));
            r.pixel_on = 1'($urandom_range(0, 1));
            send_item(r, map_pixel(r));
            if ($urandom_range(0, 149) == 0)
               drain_results();
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_vfd_pixel_address_map_unit: done, clean");
      else
         $display("tb_vfd_pixel_address_map_unit: done, errors");
      $finish;
   end

   // Hard stop well beyond the slowest correct run
   initial begin : watchdog
      #2_000_000;
      $display("tb_vfd_pixel_address_map_unit: done, errors");
      $finish;
   end

endmodule

[vfd_pixel_address_map_unit.f]
sv/vfdpam_pkg.sv
sv/vfdpam_pos_calc.sv
sv/vfd_pixel_address_map_unit.sv
dv/tb_vfd_pixel_address_map_unit.sv
